@@ sv/dcc_pkg.sv @@
`timescale 1ns / 1ps

package dcc_pkg;

   // request operations
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_WRITE    = 2'd1;
   localparam logic [1:0] KIND_TRANSFER = 2'd2;
   localparam logic [1:0] KIND_IDLE     = 2'd3;

   // register map
   localparam logic [9:0] REG_STATUS     = 10'h000;
   localparam logic [9:0] REG_FLAG_CLEAR = 10'h004;
   localparam int         SLOT_BASE      = 8'h08;
   localparam int         SLOT_STRIDE    = 8'h14;

   // word offsets inside a channel slot
   localparam logic [4:0] WORD_CTL   = 5'h00;
   localparam logic [4:0] WORD_COUNT = 5'h04;
   localparam logic [4:0] WORD_PADDR = 5'h08;
   localparam logic [4:0] WORD_MADDR = 5'h0C;

   // control word bits
   localparam int CTL_EN    = 0;
   localparam int CTL_TCIE  = 1;
   localparam int CTL_DIR   = 4;
   localparam int CTL_PINC  = 6;
   localparam int CTL_MINC  = 7;
   localparam int CTL_PSIZE = 8;
   localparam int CTL_MSIZE = 10;

   // interrupt line codes
   localparam logic [2:0] IRQ_NONE  = 3'b000;
   localparam logic [2:0] IRQ_LINE9  = 3'b001;
   localparam logic [2:0] IRQ_LINE10 = 3'b010;
   localparam logic [2:0] IRQ_LINE11 = 3'b100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUS,
      ST_SCAN
   } dcc_state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       read;
      logic       write;
      logic       step;
      logic       idle_tick;
      logic       last;
      logic [2:0] idx;
   } dcc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic act;
      logic more;
   } dcc_status_type;

endpackage

@@ sv/dma_channel_controller_top.sv @@
`timescale 1ns / 1ps

// Multi-channel DMA controller behind a register window.
// Request channel: a request is taken on a rising edge with start high and
// busy low; req_operation selects a bus read, a bus write or one tick.
// Result channel: each result is on the rsp_ ports for one cycle while
// rsp_strobe is high; rsp_last marks the final result of a request. The
// receiver cannot stall, so results are never held back.
// Bus access: a bus read or write passes through the bus state and gives its
// single result from the result registers; busy is high for one cycle, so a
// new request can be taken once the bus state is left.
// A tick steps the channel scan one channel per cycle, from channel 0 up to
// the highest channel index that is enabled with a nonzero count (only
// channel 0 when none is). Transfers come out in channel order, only for
// enabled channels with a nonzero count, each in the cycle after its scan step.
// An operation code outside the three is taken and ignored.
// Reset clears all channel registers and status flags at once; the block
// takes requests in the first cycle after reset is released.
module dma_channel_controller_top #(
   parameter int CHANNELS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_reg_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_read_data,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [2:0]  rsp_channel_number,
   output logic [2:0]  rsp_irq_raise,
   output logic        rsp_last
);

   dcc_pkg::dcc_cmd_type    cmd;
   dcc_pkg::dcc_status_type st;

   dcc_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .st            (st),
      .cmd           (cmd),
      .busy          (busy)
   );

   dcc_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_reg_offset     (req_reg_offset),
      .req_write_data     (req_write_data),
      .cmd                (cmd),
      .st                 (st),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_read_data      (rsp_read_data),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_channel_number (rsp_channel_number),
      .rsp_irq_raise      (rsp_irq_raise),
      .rsp_last           (rsp_last)
   );

endmodule

@@ sv/dcc_ctrl.sv @@
`timescale 1ns / 1ps

module dcc_ctrl #(
   parameter int CHANNELS = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_operation,
   input  dcc_pkg::dcc_status_type st,
   output dcc_pkg::dcc_cmd_type    cmd,
   output logic                    busy
);

   dcc_pkg::dcc_state_type state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [2:0]             idx_ff, idx_in;
   logic                   emitted_ff, emitted_in;

   // hold state and scan position
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dcc_pkg::ST_IDLE;
         op_ff      <= dcc_pkg::OP_READ;
         idx_ff     <= '0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         idx_ff     <= idx_in;
         emitted_ff <= emitted_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      emitted_in = emitted_ff;
      cmd        = '0;
      cmd.idx    = idx_ff;
      busy       = 1'b1;
      unique case (state_ff)
         dcc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               op_in       = req_operation;
               idx_in      = '0;
               emitted_in  = 1'b0;
               if (req_operation == dcc_pkg::OP_READ ||
                   req_operation == dcc_pkg::OP_WRITE) begin
                  state_in = dcc_pkg::ST_BUS;
               end else if (req_operation == dcc_pkg::OP_TICK) begin
                  state_in = dcc_pkg::ST_SCAN;
               end
            end
         end
         dcc_pkg::ST_BUS: begin
            cmd.read  = (op_ff == dcc_pkg::OP_READ);
            cmd.write = (op_ff == dcc_pkg::OP_WRITE);
            cmd.last  = 1'b1;
            state_in  = dcc_pkg::ST_IDLE;
         end
         dcc_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (st.act) begin
               cmd.last   = !st.more;
               emitted_in = 1'b1;
            end else if (!st.more && !emitted_ff) begin
               cmd.idle_tick = 1'b1;
               cmd.last      = 1'b1;
            end
            // advance to the next channel or finish
            if (!st.more) begin
               state_in = dcc_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         default: begin
            state_in = dcc_pkg::ST_IDLE;
         end
      endcase
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.read, cmd.write, cmd.idle_tick, cmd.step && st.act}))
      else $error("more than one result in a cycle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcc_pkg::ST_SCAN |-> {1'b0, idx_ff} < 4'(CHANNELS))
      else $error("scan index past last channel");

   a_idle_only_once: assert property (@(posedge clock) disable iff (reset)
      cmd.idle_tick |-> !emitted_ff && !st.act)
      else $error("idle tick after a transfer");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcc_pkg::ST_SCAN && !st.more |=> state_ff == dcc_pkg::ST_IDLE)
      else $error("scan did not end at last active channel");

endmodule

@@ sv/dcc_datapath.sv @@
`timescale 1ns / 1ps

module dcc_datapath #(
   parameter int CHANNELS = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [9:0]              req_reg_offset,
   input  logic [31:0]             req_write_data,
   input  dcc_pkg::dcc_cmd_type    cmd,
   output dcc_pkg::dcc_status_type st,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_kind,
   output logic [31:0]             rsp_read_data,
   output logic [31:0]             rsp_source_address,
   output logic [31:0]             rsp_dest_address,
   output logic [2:0]              rsp_channel_number,
   output logic [2:0]              rsp_irq_raise,
   output logic                    rsp_last
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [31:0] status_ff, status_in;
   logic [31:0] ctl_ff [CHANNELS];
   logic [31:0] ctl_in [CHANNELS];
   logic [31:0] cnt_ff [CHANNELS];
   logic [31:0] cnt_in [CHANNELS];
   logic [31:0] pa_ff  [CHANNELS];
   logic [31:0] pa_in  [CHANNELS];
   logic [31:0] ma_ff  [CHANNELS];
   logic [31:0] ma_in  [CHANNELS];

   logic [9:0]  off_ff;
   logic [31:0] wdata_ff;

   logic            dec_hit;
   logic [CH_W-1:0] dec_ch;
   logic [4:0]      dec_word;
   logic [9:0]      slot_lo;
   logic [9:0]      slot_hi;
   logic [9:0]      slot_rel;

   logic [CHANNELS-1:0] active;
   logic [CH_W-1:0]     sel;
   logic [31:0]         rd_ctl, rd_cnt, rd_pa, rd_ma;
   logic [31:0]         step_cnt, step_pa, step_ma;
   logic                step_done;
   logic [2:0]          step_irq;
   logic [31:0]         bus_rdata;
   logic                emit;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic [31:0] rsp_src_ff, rsp_src_in;
   logic [31:0] rsp_dst_ff, rsp_dst_in;
   logic [2:0]  rsp_ch_ff, rsp_ch_in;
   logic [2:0]  rsp_irq_ff, rsp_irq_in;
   logic        rsp_last_ff, rsp_last_in;

   // hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         off_ff   <= req_reg_offset;
         wdata_ff <= req_write_data;
      end
   end

   // decode the offset into channel slot and word
   always_comb begin
      dec_hit  = 1'b0;
      dec_ch   = '0;
      dec_word = '0;
      slot_lo  = '0;
      slot_hi  = '0;
      slot_rel = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         slot_lo  = 10'(dcc_pkg::SLOT_BASE + c * dcc_pkg::SLOT_STRIDE);
         slot_hi  = 10'(dcc_pkg::SLOT_BASE + (c + 1) * dcc_pkg::SLOT_STRIDE);
         slot_rel = off_ff - slot_lo;
         if (off_ff >= slot_lo && off_ff < slot_hi) begin
            dec_hit  = 1'b1;
            dec_ch   = CH_W'(c);
            dec_word = slot_rel[4:0];
         end
      end
   end

   assign sel    = cmd.step ? cmd.idx[CH_W-1:0] : dec_ch;
   assign rd_ctl = ctl_ff[sel];
   assign rd_cnt = cnt_ff[sel];
   assign rd_pa  = pa_ff[sel];
   assign rd_ma  = ma_ff[sel];

   // channel activity for the scan
   always_comb begin
      st.more = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         active[c] = ctl_ff[c][dcc_pkg::CTL_EN] && (cnt_ff[c] != 32'd0);
         if (active[c] && (4'(c) > {1'b0, cmd.idx})) begin
            st.more = 1'b1;
         end
      end
      st.act = cmd.step && active[sel];
   end

   // one transfer step of the selected channel
   always_comb begin
      step_cnt  = rd_cnt - 32'd1;
      step_pa   = rd_pa + (32'd1 << rd_ctl[dcc_pkg::CTL_PSIZE +: 2]);
      step_ma   = rd_ma + (32'd1 << rd_ctl[dcc_pkg::CTL_MSIZE +: 2]);
      step_done = (step_cnt == 32'd0);
      step_irq  = dcc_pkg::IRQ_NONE;
      if (step_done && rd_ctl[dcc_pkg::CTL_TCIE]) begin
         if (cmd.idx == 3'd0) begin
            step_irq = dcc_pkg::IRQ_LINE9;
         end else if (cmd.idx <= 3'd2) begin
            step_irq = dcc_pkg::IRQ_LINE10;
         end else begin
            step_irq = dcc_pkg::IRQ_LINE11;
         end
      end
   end

   // bus read mux
   always_comb begin
      bus_rdata = '0;
      if (off_ff == dcc_pkg::REG_STATUS) begin
         bus_rdata = status_ff;
      end else if (dec_hit) begin
         unique case (dec_word)
            dcc_pkg::WORD_CTL:   bus_rdata = rd_ctl;
            dcc_pkg::WORD_COUNT: bus_rdata = rd_cnt;
            dcc_pkg::WORD_PADDR: bus_rdata = rd_pa;
            dcc_pkg::WORD_MADDR: bus_rdata = rd_ma;
            default:             bus_rdata = '0;
         endcase
      end
   end

   // register file updates from bus writes and transfer steps
   always_comb begin
      status_in = status_ff;
      ctl_in    = ctl_ff;
      cnt_in    = cnt_ff;
      pa_in     = pa_ff;
      ma_in     = ma_ff;
      if (cmd.write) begin
         if (off_ff == dcc_pkg::REG_FLAG_CLEAR) begin
            status_in = status_ff & ~wdata_ff;
         end else if (dec_hit) begin
            unique case (dec_word)
               dcc_pkg::WORD_CTL:   ctl_in[dec_ch] = wdata_ff;
               dcc_pkg::WORD_COUNT: cnt_in[dec_ch] = wdata_ff;
               dcc_pkg::WORD_PADDR: pa_in[dec_ch]  = wdata_ff;
               dcc_pkg::WORD_MADDR: ma_in[dec_ch]  = wdata_ff;
               default: ;
            endcase
         end
      end
      if (st.act) begin
         cnt_in[sel] = step_cnt;
         if (rd_ctl[dcc_pkg::CTL_PINC]) begin
            pa_in[sel] = step_pa;
         end
         if (rd_ctl[dcc_pkg::CTL_MINC]) begin
            ma_in[sel] = step_ma;
         end
         if (step_done) begin
            status_in[{cmd.idx, 2'b01}] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            ctl_ff[c] <= '0;
            cnt_ff[c] <= '0;
            pa_ff[c]  <= '0;
            ma_ff[c]  <= '0;
         end
      end else begin
         status_ff <= status_in;
         ctl_ff    <= ctl_in;
         cnt_ff    <= cnt_in;
         pa_ff     <= pa_in;
         ma_ff     <= ma_in;
      end
   end

   // build the next result
   assign emit = cmd.read || cmd.write || cmd.idle_tick || st.act;

   always_comb begin
      rsp_strobe_in    = emit;
      rsp_kind_in      = dcc_pkg::KIND_IDLE;
      rsp_read_data_in = '0;
      rsp_src_in       = '0;
      rsp_dst_in       = '0;
      rsp_ch_in        = '0;
      rsp_irq_in       = dcc_pkg::IRQ_NONE;
      rsp_last_in      = cmd.last;
      if (cmd.read) begin
         rsp_kind_in      = dcc_pkg::KIND_READ;
         rsp_read_data_in = bus_rdata;
      end else if (cmd.write) begin
         rsp_kind_in = dcc_pkg::KIND_WRITE;
      end else if (st.act) begin
         rsp_kind_in = dcc_pkg::KIND_TRANSFER;
         rsp_ch_in   = cmd.idx;
         rsp_irq_in  = step_irq;
         if (rd_ctl[dcc_pkg::CTL_DIR]) begin
            rsp_src_in = rd_ma;
            rsp_dst_in = rd_pa;
         end else begin
            rsp_src_in = rd_pa;
            rsp_dst_in = rd_ma;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff      <= rsp_kind_in;
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_src_ff       <= rsp_src_in;
         rsp_dst_ff       <= rsp_dst_in;
         rsp_ch_ff        <= rsp_ch_in;
         rsp_irq_ff       <= rsp_irq_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_source_address = rsp_src_ff;
   assign rsp_dest_address   = rsp_dst_ff;
   assign rsp_channel_number = rsp_ch_ff;
   assign rsp_irq_raise      = rsp_irq_ff;
   assign rsp_last           = rsp_last_ff;

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_kind_ff != dcc_pkg::KIND_TRANSFER |-> rsp_last_ff)
      else $error("single result without last");

   a_irq_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_irq_ff != dcc_pkg::IRQ_NONE |->
         rsp_kind_ff == dcc_pkg::KIND_TRANSFER && $onehot(rsp_irq_ff))
      else $error("interrupt outside a completing transfer");

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      st.act && step_done |=> status_ff[{$past(cmd.idx), 2'b01}])
      else $error("completion flag not set");

endmodule
